[sv/pvs_pkg.sv]
// Package: shared types, constants and the sine table function for the voice synth.
`default_nettype none
package pvs_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_NOTE    = 2'd1,
    KIND_REL_CH  = 2'd2,
    KIND_REL_ALL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SHAPE_SINE  = 2'd0,
    SHAPE_PULSE = 2'd1,
    SHAPE_FALL  = 2'd2,
    SHAPE_RISE  = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  localparam int REG_ROW_SAMPLES = 0;
  localparam int REG_ROW_RECIP   = 1;
  localparam int REG_GAIN_SHIFT  = 2;

  localparam logic [16:0] SIN_A = 17'd51472;
  localparam logic [16:0] SIN_B = 17'd21167;
  localparam logic [16:0] SIN_C = 17'd2605;

  // Word passed from front to back through the queue.
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  channel;
    logic [1:0]  wave_shape;
    logic [22:0] phase_step;
    logic        release_now;
  } cmd_t;

  // Quarter-wave polynomial, evaluated at elaboration for the constant table.
  function automatic logic signed [15:0] sine_poly(input logic [23:0] phase);
    logic [1:0]  quad;
    logic [21:0] r;
    logic [63:0] z, z2, inner, poly, v;
    quad = phase[23:22];
    r = phase[21:0];
    z = quad[0] ? 64'((23'h400000 - {1'b0, r}) >> 7) : 64'(r >> 7);
    z2 = (z * z) >> 15;
    inner = 64'(SIN_B) - ((z2 * 64'(SIN_C)) >> 15);
    poly = 64'(SIN_A) - ((z2 * inner) >> 15);
    v = (z * poly) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return quad[1] ? -16'(v) : 16'(v);
  endfunction

endpackage
`default_nettype wire

[sv/pvs_front.sv]
// Front end: takes input words and queues commands for the back end.
`default_nettype none
module pvs_front #(
  parameter int CHANNELS = 16,
  parameter int QDEPTH   = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   kind,
  input  wire logic [3:0]   channel,
  input  wire logic [1:0]   wave_shape,
  input  wire logic [22:0]  phase_step,
  input  wire logic         release_now,
  output logic              cmd_valid,
  output pvs_pkg::cmd_t     cmd,
  input  wire logic         cmd_take
);
  import pvs_pkg::*;

  localparam int QW = $clog2(QDEPTH);

  cmd_t          q [QDEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [QW:0]   count;
  cmd_t          in_cmd;
  logic          do_push, do_pop;

  // Classify: reduce channel to the configured channel count by a constant lookup
  always_comb begin
    in_cmd.kind        = kind;
    in_cmd.channel     = '0;
    for (int i = 0; i < 16; i++) begin
      if (channel == 4'(i)) in_cmd.channel = 6'(i % CHANNELS);
    end
    in_cmd.wave_shape  = wave_shape;
    in_cmd.phase_step  = phase_step;
    in_cmd.release_now = release_now;
  end

  assign full      = (count == (QW+1)'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Hold queued words
  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= in_cmd;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == QW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == QW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (QW+1)'(do_push) - (QW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

[sv/pvs_back.sv]
// Back end: voice bank sequencer, serial mixer and result register.
`default_nettype none
module pvs_back #(
  parameter int VOICES       = 16,
  parameter int SINE_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  pvs_pkg::cmd_t           cmd,
  output logic                    cmd_take,
  input  wire logic [15:0]        row_samples,
  input  wire logic [15:0]        row_recip,
  input  wire logic [2:0]         gain_shift,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      sample,
  output logic                    accepted
);
  import pvs_pkg::*;

  localparam int VW = $clog2(VOICES);
  localparam int SW = $clog2(SINE_ENTRIES);
  localparam int AW = 16 + 17 + VW + 1;

  // Constant sine table, built at elaboration
  function automatic logic [16*SINE_ENTRIES-1:0] build_sine();
    logic [16*SINE_ENTRIES-1:0] t;
    t = '0;
    for (int i = 0; i < SINE_ENTRIES; i++)
      t[16*i +: 16] = sine_poly(24'((64'(i) << 24) / SINE_ENTRIES));
    return t;
  endfunction

  localparam logic [16*SINE_ENTRIES-1:0] SINE_TAB = build_sine();

  // Voice state: fixed-place registers per voice
  logic [23:0] v_phase   [VOICES];
  logic [22:0] v_step    [VOICES];
  logic [1:0]  v_shape   [VOICES];
  logic [5:0]  v_chan    [VOICES];
  logic [15:0] v_fade    [VOICES];
  logic [VOICES-1:0] v_busy, v_fading;

  state_t        state, state_next;
  logic [VW:0]   idx;
  logic [VW-1:0] vi;
  logic signed [AW-1:0] acc;
  logic signed [15:0]   wave_r;
  logic [16:0]          env_r;
  logic signed [33:0]   prod_r;
  logic                 prod_ok;

  // Result being built, then the output register
  logic signed [15:0] pend_sample;
  logic               pend_acc;
  logic               res_full;
  logic signed [15:0] res_sample;
  logic               res_acc;

  assign vi = idx[VW-1:0];
  assign empty = !res_full;
  assign sample = res_sample;
  assign accepted = res_acc;

  // Wave of the selected voice
  logic signed [15:0] wave_c;
  logic [23:0]        ph;
  logic [31:0]        env_full;
  always_comb begin
    ph = v_phase[vi];
    case (shape_t'(v_shape[vi]))
      SHAPE_SINE:  wave_c = $signed(SINE_TAB[{ph[23 -: SW], 4'b0000} +: 16]);
      SHAPE_PULSE: wave_c = ph[23] ? -16'sd32767 : 16'sd32767;
      SHAPE_FALL:  wave_c = (ph[23:8] == 16'd0) ? 16'sd32767 : 16'(17'd32768 - {1'b0, ph[23:8]});
      default:     wave_c = 16'({1'b0, ph[23:8]} - 17'd32768);
    endcase
    env_full = 32'(v_fade[vi]) * 32'(row_recip);
  end

  // Final scale and saturate
  logic signed [AW-1:0] shifted;
  logic signed [15:0]   sat_c;
  always_comb begin
    shifted = acc >>> (5'd16 + 5'(gain_shift));
    if (shifted > AW'(32767))       sat_c = 16'sd32767;
    else if (shifted < -AW'(32768)) sat_c = -16'sd32768;
    else                            sat_c = shifted[15:0];
  end

  // Lowest free voice for a note
  logic          found;
  logic [VW-1:0] free_v;
  always_comb begin
    found = 1'b0;
    free_v = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!v_busy[i]) begin
        found = 1'b1;
        free_v = VW'(i);
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    case (state)
      ST_IDLE: if (cmd_valid) begin
        cmd_take = 1'b1;
        state_next = (kind_t'(cmd.kind) == KIND_TICK) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: state_next = (idx == (VW+1)'(VOICES)) ? ST_ACC : ST_MUL;
      ST_MUL:  state_next = ST_SCAN;
      ST_ACC:  state_next = ST_DONE;
      ST_DONE: if (!res_full || pop) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Datapath: scan voices one at a time through SCAN and MUL, multiply registered, then add
  always_ff @(posedge clk) begin
    if (rst) begin
      v_busy   <= '0;
      v_fading <= '0;
      prod_ok  <= 1'b0;
      idx      <= '0;
      acc      <= '0;
    end else begin
      case (state)
        ST_IDLE: if (cmd_valid) begin
          idx <= '0;
          acc <= '0;
          prod_ok <= 1'b0;
          if (kind_t'(cmd.kind) == KIND_NOTE) begin
            pend_acc <= found;
            if (found) begin
              v_busy[free_v]   <= 1'b1;
              v_fading[free_v] <= cmd.release_now;
              v_fade[free_v]   <= cmd.release_now ? row_samples : 16'd0;
              v_phase[free_v]  <= '0;
              v_step[free_v]   <= cmd.phase_step;
              v_shape[free_v]  <= cmd.wave_shape;
              v_chan[free_v]   <= cmd.channel;
            end
          end else begin
            pend_acc <= 1'b1;
          end
          if (kind_t'(cmd.kind) == KIND_REL_CH || kind_t'(cmd.kind) == KIND_REL_ALL) begin
            for (int i = 0; i < VOICES; i++) begin
              if (v_busy[i] && !v_fading[i] &&
                  (kind_t'(cmd.kind) == KIND_REL_ALL || v_chan[i] == cmd.channel)) begin
                v_fading[i] <= 1'b1;
                v_fade[i]   <= row_samples;
              end
            end
          end
          pend_sample <= '0;
        end
        ST_SCAN: begin
          if (prod_ok) acc <= acc + AW'(prod_r);
          prod_ok <= 1'b0;
          if (idx != (VW+1)'(VOICES)) begin
            if (v_busy[vi]) begin
              if (v_fading[vi] && v_fade[vi] == 16'd0) begin
                v_busy[vi] <= 1'b0;
                v_fading[vi] <= 1'b0;
              end else begin
                wave_r <= wave_c;
                env_r <= !v_fading[vi] ? 17'd65536 :
                         (env_full > 32'd65536) ? 17'd65536 : env_full[16:0];
                prod_ok <= 1'b1;
                v_phase[vi] <= v_phase[vi] + 24'(v_step[vi]);
                if (v_fading[vi]) begin
                  v_fade[vi] <= v_fade[vi] - 16'd1;
                  if (v_fade[vi] == 16'd1) begin
                    v_busy[vi] <= 1'b0;
                    v_fading[vi] <= 1'b0;
                  end
                end
              end
            end
          end
        end
        ST_MUL: begin
          if (prod_ok) prod_r <= wave_r * $signed({1'b0, env_r});
          idx <= idx + 1'b1;
        end
        ST_ACC: pend_sample <= sat_c;
        default: ;
      endcase
    end
  end

  // Result register: load the finished word once the previous one has gone
  always_ff @(posedge clk) begin
    if (rst) res_full <= 1'b0;
    else if (state == ST_DONE && (!res_full || pop)) begin
      res_full   <= 1'b1;
      res_sample <= pend_sample;
      res_acc    <= pend_acc;
    end
    else if (pop) res_full <= 1'b0;
  end
endmodule
`default_nettype wire

[sv/polyphonic_voice_synth_top.sv]
// Top level: polyphonic oscillator bank, front queue plus voice sequencer.
// The back end handles one item at a time; a tick is paced by the serial voice scan.
// A four-word command queue lets input words be taken while the back end works.
// Reset (rst, synchronous, high) clears all voices, queues and the config to defaults.
`default_nettype none
module polyphonic_voice_synth_top #(
  parameter int VOICES       = 16,
  parameter int CHANNELS     = 16,
  parameter int SINE_ENTRIES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   kind,
  input  wire logic [3:0]   channel,
  input  wire logic [1:0]   wave_shape,
  input  wire logic [22:0]  phase_step,
  input  wire logic         release_now,
  output logic              empty,
  input  wire logic         pop,
  output logic signed [15:0] sample,
  output logic              accepted,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import pvs_pkg::*;

  logic [15:0] row_samples, row_recip;
  logic [2:0]  gain_shift;
  logic        cmd_valid, cmd_take;
  cmd_t        cmd;

  // Hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_samples <= 16'd4410;
      row_recip   <= 16'd14;
      gain_shift  <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(REG_ROW_SAMPLES): row_samples <= cfg_data;
        2'(REG_ROW_RECIP):   row_recip   <= cfg_data;
        2'(REG_GAIN_SHIFT):  gain_shift  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  pvs_front #(.CHANNELS(CHANNELS), .QDEPTH(4)) u_front (
    .clk, .rst, .push, .full, .kind, .channel, .wave_shape, .phase_step,
    .release_now, .cmd_valid, .cmd, .cmd_take
  );

  pvs_back #(.VOICES(VOICES), .SINE_ENTRIES(SINE_ENTRIES)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .row_samples, .row_recip,
    .gain_shift, .empty, .pop, .sample, .accepted
  );

`ifndef SYNTHESIS
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !cmd_take) |=> full) else $error("queue full dropped without take");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("take from empty queue");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sample))) else $error("result lost");
`endif
endmodule
`default_nettype wire
